/* src/lest_pkg.sv */
// Shared types, codes and helpers for the login event statistics table.
package lest_pkg;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_INVALID = 1'b1;

  localparam logic [1:0] KIND_SUCCESS = 2'd0;
  localparam logic [1:0] KIND_FAILURE = 2'd1;

  // Broadcast to every cell during the update cycle.
  typedef struct packed {
    logic        upd;
    logic        rec;
    logic [1:0]  kind;
    logic        src_add;
    logic        acc_add;
    logic [63:0] src_key;
    logic [63:0] acc_key;
  } cell_cmd_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

/* src/lest_cell.sv */
// One table slot: a source entry, an account entry and a stage of the top search.
module lest_cell #(
  parameter int IDX = 0,
  parameter int KEY_BITS = 64,
  parameter int CNT_W = 7,
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  logic [CNT_W-1:0]    src_fill,
  input  logic [CNT_W-1:0]    acc_fill,
  input  lest_pkg::cell_cmd_t cmd,
  input  logic                src_sel,
  input  logic                acc_sel,
  output logic                src_hit,
  output logic                acc_hit,
  output logic [31:0]         src_fail,
  output logic [31:0]         src_peak,
  output logic [31:0]         acc_fail,
  input  logic [31:0]         src_left_val,
  input  logic [IDX_W-1:0]    src_left_idx,
  input  logic [31:0]         acc_left_val,
  input  logic [IDX_W-1:0]    acc_left_idx,
  output logic [31:0]         src_best_val,
  output logic [IDX_W-1:0]    src_best_idx,
  output logic [31:0]         acc_best_val,
  output logic [IDX_W-1:0]    acc_best_idx
);
  import lest_pkg::*;

  logic [KEY_BITS-1:0] src_key;
  logic [31:0]         src_succ;
  logic [31:0]         src_streak;
  logic [KEY_BITS-1:0] acc_key;
  logic [31:0]         acc_succ;
  logic                src_active;
  logic                acc_active;
  logic [31:0]         b_succ, b_fail, b_streak, b_peak, s_run;
  logic [31:0]         ba_succ, ba_fail;

  assign src_active = CNT_W'(IDX) < src_fill;
  assign acc_active = CNT_W'(IDX) < acc_fill;
  assign src_hit = src_active && (src_key == cmd.src_key[KEY_BITS-1:0]);
  assign acc_hit = acc_active && (acc_key == cmd.acc_key[KEY_BITS-1:0]);

  always_comb begin
    b_succ   = cmd.src_add ? 32'd0 : src_succ;
    b_fail   = cmd.src_add ? 32'd0 : src_fail;
    b_streak = cmd.src_add ? 32'd0 : src_streak;
    b_peak   = cmd.src_add ? 32'd0 : src_peak;
    ba_succ  = cmd.acc_add ? 32'd0 : acc_succ;
    ba_fail  = cmd.acc_add ? 32'd0 : acc_fail;
    s_run    = sat_inc(b_streak);
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && src_sel) begin
      if (cmd.src_add) begin
        src_key <= cmd.src_key[KEY_BITS-1:0];
      end
      src_succ   <= b_succ;
      src_fail   <= b_fail;
      src_streak <= b_streak;
      src_peak   <= b_peak;
      if (cmd.rec && cmd.kind == KIND_SUCCESS) begin
        src_succ   <= sat_inc(b_succ);
        src_streak <= 32'd0;
      end else if (cmd.rec && cmd.kind == KIND_FAILURE) begin
        src_fail   <= sat_inc(b_fail);
        src_streak <= s_run;
        src_peak   <= (s_run > b_peak) ? s_run : b_peak;
      end
    end
    if (cmd.upd && acc_sel) begin
      if (cmd.acc_add) begin
        acc_key <= cmd.acc_key[KEY_BITS-1:0];
      end
      acc_succ <= ba_succ;
      acc_fail <= ba_fail;
      if (cmd.rec && cmd.kind == KIND_SUCCESS) begin
        acc_succ <= sat_inc(ba_succ);
      end else if (cmd.rec && cmd.kind == KIND_FAILURE) begin
        acc_fail <= sat_inc(ba_fail);
      end
    end
  end

  // Running maximum handed along the row; a strict compare keeps the lowest slot on a tie.
  always_ff @(posedge clk) begin
    if (src_active && src_fail > src_left_val) begin
      src_best_val <= src_fail;
      src_best_idx <= IDX_W'(IDX);
    end else begin
      src_best_val <= src_left_val;
      src_best_idx <= src_left_idx;
    end
    if (acc_active && acc_fail > acc_left_val) begin
      acc_best_val <= acc_fail;
      acc_best_idx <= IDX_W'(IDX);
    end else begin
      acc_best_val <= acc_left_val;
      acc_best_idx <= acc_left_idx;
    end
  end

endmodule

/* src/login_event_stats_table.sv */
// Top level of the login event statistics table.
// Input words (operation, source_key, account_key, event_kind) arrive on a
// valid/ready channel; one result word leaves per input word on a second
// valid/ready channel. Each slot of both tables lives in one cell of a row.
// An item passes through a parallel key compare (S_LOOK), an update in the
// selected cells (S_UPD), then a search (S_SCAN) while the running maximum
// of failures is handed from cell to cell along the row; the result is
// registered at the end of the search. No new word is taken until the
// current item is done; in_ready is high only while the block is
// idle; the next word can be taken while a result still waits at the output.
// A finished item holds in the search state until the output register is
// free, so a stalled receiver stalls the input after at most one more word.
// Reset empties both tables (fill counts to zero) and clears all global
// counters; slot contents are not cleared and are never read before written.
module login_event_stats_table #(
  parameter int TABLE_SLOTS = 64,
  parameter int KEY_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [63:0] source_key,
  input  logic [63:0] account_key,
  input  logic [1:0]  event_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [6:0]  source_slot,
  output logic [6:0]  account_slot,
  output logic [31:0] source_fail_total,
  output logic [31:0] source_worst_streak,
  output logic [31:0] account_fail_total,
  output logic [6:0]  top_source_slot,
  output logic [6:0]  top_account_slot,
  output logic [31:0] valid_total,
  output logic [31:0] success_total,
  output logic [31:0] failure_total,
  output logic [31:0] ignored_total
);
  import lest_pkg::*;

  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [CNT_W-1:0] NONE = CNT_W'(TABLE_SLOTS);
  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_UPD  = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  state_t     state;
  logic       op;
  logic [1:0] kind;
  logic [63:0] src_key, acc_key;
  cell_cmd_t  cmd;
  logic [CNT_W-1:0] src_fill, acc_fill, s_slot, a_slot, scnt;
  logic s_add, a_add;
  logic [31:0] valid_count, success_count, failure_count, ignored_count;
  logic rec;

  logic [TABLE_SLOTS-1:0] src_hit, acc_hit, s_sel, a_sel;
  logic [31:0] c_sfail [TABLE_SLOTS];
  logic [31:0] c_speak [TABLE_SLOTS];
  logic [31:0] c_afail [TABLE_SLOTS];
  logic [31:0]      s_bv [TABLE_SLOTS+1];
  logic [IDX_W-1:0] s_bi [TABLE_SLOTS+1];
  logic [31:0]      a_bv [TABLE_SLOTS+1];
  logic [IDX_W-1:0] a_bi [TABLE_SLOTS+1];

  logic [IDX_W-1:0] s_enc, a_enc;
  logic [31:0] s_fail_rd, s_peak_rd, a_fail_rd;
  logic done;

  assign s_bv[0] = 32'd0;
  assign s_bi[0] = '0;
  assign a_bv[0] = 32'd0;
  assign a_bi[0] = '0;

  genvar g;
  generate
    for (g = 0; g < TABLE_SLOTS; g++) begin : g_cell
      lest_cell #(.IDX(g), .KEY_BITS(KEY_BITS), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_cell (
        .clk(clk), .src_fill(src_fill), .acc_fill(acc_fill), .cmd(cmd),
        .src_sel(s_sel[g]), .acc_sel(a_sel[g]),
        .src_hit(src_hit[g]), .acc_hit(acc_hit[g]),
        .src_fail(c_sfail[g]), .src_peak(c_speak[g]), .acc_fail(c_afail[g]),
        .src_left_val(s_bv[g]), .src_left_idx(s_bi[g]),
        .acc_left_val(a_bv[g]), .acc_left_idx(a_bi[g]),
        .src_best_val(s_bv[g+1]), .src_best_idx(s_bi[g+1]),
        .acc_best_val(a_bv[g+1]), .acc_best_idx(a_bi[g+1])
      );
      assign s_sel[g] = (s_slot == CNT_W'(g));
      assign a_sel[g] = (a_slot == CNT_W'(g));
    end
  endgenerate

  // Keys in a table are unique, so at most one cell hits.
  always_comb begin
    s_enc = '0;
    a_enc = '0;
    s_fail_rd = 32'd0;
    s_peak_rd = 32'd0;
    a_fail_rd = 32'd0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      s_enc = s_enc | (src_hit[i] ? IDX_W'(i) : '0);
      a_enc = a_enc | (acc_hit[i] ? IDX_W'(i) : '0);
      s_fail_rd = s_fail_rd | (s_sel[i] ? c_sfail[i] : 32'd0);
      s_peak_rd = s_peak_rd | (s_sel[i] ? c_speak[i] : 32'd0);
      a_fail_rd = a_fail_rd | (a_sel[i] ? c_afail[i] : 32'd0);
    end
  end

  assign rec = (op == OP_EVENT) && (s_slot != NONE) && (a_slot != NONE);
  assign in_ready = (state == S_IDLE);
  assign done = (state == S_SCAN) && (scnt == NONE) && (!out_valid || out_ready);

  always_comb begin
    cmd.upd = (state == S_UPD);
    cmd.rec = rec;
    cmd.kind = kind;
    cmd.src_add = s_add;
    cmd.acc_add = a_add;
    cmd.src_key = src_key;
    cmd.acc_key = acc_key;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op <= operation;
      kind <= event_kind;
      src_key <= source_key & KEY_MASK;
      acc_key <= account_key & KEY_MASK;
    end
    if (state == S_LOOK) begin
      if (op == OP_INVALID) begin
        s_slot <= NONE;
        a_slot <= NONE;
        s_add <= 1'b0;
        a_add <= 1'b0;
      end else begin
        s_slot <= (|src_hit) ? CNT_W'(s_enc) : ((src_fill < NONE) ? src_fill : NONE);
        a_slot <= (|acc_hit) ? CNT_W'(a_enc) : ((acc_fill < NONE) ? acc_fill : NONE);
        s_add <= !(|src_hit) && (src_fill < NONE);
        a_add <= !(|acc_hit) && (acc_fill < NONE);
      end
    end
    if (done) begin
      accepted <= rec;
      source_slot <= 7'(s_slot);
      account_slot <= 7'(a_slot);
      source_fail_total <= s_fail_rd;
      source_worst_streak <= s_peak_rd;
      account_fail_total <= a_fail_rd;
      top_source_slot <= (src_fill == '0) ? 7'(NONE) : 7'(s_bi[TABLE_SLOTS]);
      top_account_slot <= (acc_fill == '0) ? 7'(NONE) : 7'(a_bi[TABLE_SLOTS]);
      valid_total <= valid_count;
      success_total <= success_count;
      failure_total <= failure_count;
      ignored_total <= ignored_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      src_fill <= '0;
      acc_fill <= '0;
      scnt <= '0;
      valid_count <= 32'd0;
      success_count <= 32'd0;
      failure_count <= 32'd0;
      ignored_count <= 32'd0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (op == OP_INVALID) begin
            ignored_count <= sat_inc(ignored_count);
          end
          if (s_add) begin
            src_fill <= src_fill + CNT_W'(1);
          end
          if (a_add) begin
            acc_fill <= acc_fill + CNT_W'(1);
          end
          if (rec) begin
            valid_count <= sat_inc(valid_count);
            if (kind == KIND_SUCCESS) begin
              success_count <= sat_inc(success_count);
            end else if (kind == KIND_FAILURE) begin
              failure_count <= sat_inc(failure_count);
            end
          end
          scnt <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (scnt != NONE) begin
            scnt <= scnt + CNT_W'(1);
          end else if (done) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/lest_check.sv */
// Port-level checks for the login event statistics table, bound to the top level.
module lest_check #(
  parameter int TABLE_SLOTS = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        accepted,
  input logic [6:0]  source_slot,
  input logic [6:0]  account_slot,
  input logic [31:0] source_fail_total,
  input logic [31:0] account_fail_total
);
  localparam logic [6:0] NONE7 = 7'(TABLE_SLOTS);

  // A word is worked on alone: after an accept the input closes.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_recorded_has_slots: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> (source_slot != NONE7) && (account_slot != NONE7))
    else $error("recorded event without both slots");

  a_no_entry_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (account_slot == NONE7) |-> (account_fail_total == 32'd0) && !accepted)
    else $error("missing account entry reports a total");

  a_no_src_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (source_slot == NONE7) |-> (source_fail_total == 32'd0))
    else $error("missing source entry reports a total");

endmodule

bind login_event_stats_table lest_check #(.TABLE_SLOTS(TABLE_SLOTS)) u_lest_check (.*);
